/* rtl/core/bta_pkg.sv */
// Shared types and constants of the boundary-tag first-fit allocator.
package bta_pkg;

   localparam int HEAP_GRANULES = 4096;
   localparam int GRAN_BYTES    = 16;
   localparam int IDX_W         = $clog2(HEAP_GRANULES);
   localparam int SIZE_W        = IDX_W + 1;
   localparam int SPAN_W        = IDX_W + 2;
   localparam int GSH           = $clog2(GRAN_BYTES);
   localparam int REQ_W         = 21;
   localparam int ADDR_W        = 16;
   localparam int NEED_W        = REQ_W - GSH + 1;
   localparam int BYTES_W       = 17;
   localparam int CNT_W         = 32;
   localparam int MIN_GRANULES  = 3;

   localparam logic [CNT_W-1:0] CNT_RESET =
      CNT_W'(HEAP_GRANULES * GRAN_BYTES - 2 * GRAN_BYTES);
   localparam logic [CNT_W-1:0] OVERHEAD_BYTES = CNT_W'(2 * GRAN_BYTES);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_IGNORED  = 2'd2;

   typedef struct packed {
      logic              op;
      logic              ign;
      logic [NEED_W-1:0] need;
      logic [IDX_W-1:0]  hdr;
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic              is_free;
      logic [SIZE_W-1:0] size;
   } tag_type;

endpackage

/* rtl/core/bta_front.sv */
// Front stage: accepts requests and classifies them into engine commands.
module bta_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_op,
   input  logic [bta_pkg::REQ_W-1:0]    req_bytes,
   input  logic [bta_pkg::ADDR_W-1:0]   req_addr,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output bta_pkg::cmd_type             cmd
);

   logic             valid_ff, valid_in;
   bta_pkg::cmd_type cmd_ff, cmd_in;
   logic [bta_pkg::REQ_W:0] rounded;
   logic             bad_ptr;

   assign req_tready = enable && (!valid_ff || cmd_ready);
   assign cmd_valid  = valid_ff;
   assign cmd        = cmd_ff;

   always_comb begin
      rounded = {1'b0, req_bytes} + (bta_pkg::REQ_W+1)'(bta_pkg::GRAN_BYTES - 1);
      // Pointers must be granule aligned and at least one granule past the start.
      bad_ptr = (req_addr < bta_pkg::ADDR_W'(bta_pkg::GRAN_BYTES)) ||
                (req_addr[bta_pkg::GSH-1:0] != '0);
      cmd_in.op   = req_op;
      cmd_in.need = bta_pkg::NEED_W'(rounded >> bta_pkg::GSH) + bta_pkg::NEED_W'(2);
      cmd_in.hdr  = bta_pkg::IDX_W'((req_addr >> bta_pkg::GSH) - bta_pkg::ADDR_W'(1));
      if (req_op == bta_pkg::OP_ALLOC) begin
         cmd_in.ign = (req_bytes == '0);
      end else begin
         cmd_in.ign = bad_ptr;
      end
      valid_in = valid_ff;
      if (cmd_ready) begin
         valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

/* rtl/core/bta_queue.sv */
// Two-entry command queue between the front stage and the engine.
module bta_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bta_pkg::cmd_type push_cmd,
   output logic             not_full,
   input  logic             pop,
   output logic             not_empty,
   output bta_pkg::cmd_type pop_cmd
);

   bta_pkg::cmd_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign not_full  = (cnt_ff != 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_cmd   = slot_ff[rd_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = wr_ff ^ do_push;
      rd_in  = rd_ff ^ do_pop;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/bta_engine.sv */
// Back end: tag memories, first-fit walk, block free with merging, result register.
module bta_engine (
   input  logic                          clock,
   input  logic                          reset,
   output logic                          ready_init,
   input  logic                          cmd_valid,
   output logic                          cmd_pop,
   input  bta_pkg::cmd_type              cmd,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [1:0]                    rsp_status,
   output logic [bta_pkg::ADDR_W-1:0]    rsp_uaddr,
   output logic [bta_pkg::BYTES_W-1:0]   rsp_bbytes,
   output logic [bta_pkg::CNT_W-1:0]     rsp_count
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_A_RD   = 4'd2;
   localparam logic [3:0] S_A_CHK  = 4'd3;
   localparam logic [3:0] S_TAKE   = 4'd4;
   localparam logic [3:0] S_F_RD   = 4'd5;
   localparam logic [3:0] S_F_CHK  = 4'd6;
   localparam logic [3:0] S_F_NRD  = 4'd7;
   localparam logic [3:0] S_F_NCHK = 4'd8;
   localparam logic [3:0] S_F_PREV = 4'd9;
   localparam logic [3:0] S_F_FCHK = 4'd10;
   localparam logic [3:0] S_F_PRD  = 4'd11;
   localparam logic [3:0] S_F_PCHK = 4'd12;
   localparam logic [3:0] S_PB_H   = 4'd13;
   localparam logic [3:0] S_PB_F   = 4'd14;
   localparam logic [3:0] S_DONE   = 4'd15;

   localparam int IW = bta_pkg::IDX_W;
   localparam int SW = bta_pkg::SIZE_W;
   localparam int PW = bta_pkg::SPAN_W;
   localparam int NW = bta_pkg::NEED_W;
   localparam int CW = bta_pkg::CNT_W;
   localparam int BW = bta_pkg::BYTES_W;
   localparam logic [PW-1:0] HEAP_END = PW'(bta_pkg::HEAP_GRANULES);

   bta_pkg::tag_type hdr_mem [bta_pkg::HEAP_GRANULES];
   logic [SW-1:0]    ftr_mem [bta_pkg::HEAP_GRANULES];
   bta_pkg::tag_type hdr_rd_ff;
   logic [SW-1:0]    ftr_rd_ff;

   logic             hdr_we, ftr_we;
   logic [IW-1:0]    hdr_waddr, hdr_raddr, ftr_waddr, ftr_raddr;
   bta_pkg::tag_type hdr_wdata;
   logic [SW-1:0]    ftr_wdata;

   logic [3:0]       state_ff, state_in, ret_ff, ret_in;
   logic [IW-1:0]    clr_ff, clr_in;
   bta_pkg::cmd_type cmd_ff, cmd_in;
   logic [PW-1:0]    cur_ff, cur_in, size_ff, size_in;
   logic [IW-1:0]    prev_ff, prev_in;
   logic [PW-1:0]    pb_base_ff, pb_base_in, pb_size_ff, pb_size_in;
   logic             pb_free_ff, pb_free_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [1:0]       st_ff, st_in;
   logic [bta_pkg::ADDR_W-1:0] ua_ff, ua_in;
   logic [BW-1:0]    bb_ff, bb_in;
   logic             out_v_ff, out_v_in;
   logic [1:0]       o_st_ff;
   logic [bta_pkg::ADDR_W-1:0] o_ua_ff;
   logic [BW-1:0]    o_bb_ff;
   logic [CW-1:0]    o_cnt_ff;
   logic             load;

   logic [PW-1:0]    pb_foot, nxt, rem;
   logic             foot_ok;

   function automatic logic [CW-1:0] to_bytes(input logic [PW-1:0] g);
      return CW'(g) << bta_pkg::GSH;
   endfunction

   function automatic logic [BW-1:0] to_bbytes(input logic [PW-1:0] g);
      return BW'(g) << bta_pkg::GSH;
   endfunction

   assign ready_init = (state_ff != S_CLEAR);
   assign rsp_tvalid = out_v_ff;
   assign rsp_status = o_st_ff;
   assign rsp_uaddr  = o_ua_ff;
   assign rsp_bbytes = o_bb_ff;
   assign rsp_count  = o_cnt_ff;

   always_comb begin
      pb_foot = pb_base_ff + pb_size_ff - PW'(1);
      foot_ok = (pb_size_ff != '0) && (pb_foot < HEAP_END);
      nxt     = PW'(cmd_ff.hdr) + size_ff;
      rem     = PW'(hdr_rd_ff.size) - PW'(cmd_ff.need);

      state_in   = state_ff;
      ret_in     = ret_ff;
      clr_in     = clr_ff;
      cmd_in     = cmd_ff;
      cur_in     = cur_ff;
      size_in    = size_ff;
      prev_in    = prev_ff;
      pb_base_in = pb_base_ff;
      pb_size_in = pb_size_ff;
      pb_free_in = pb_free_ff;
      cnt_in     = cnt_ff;
      st_in      = st_ff;
      ua_in      = ua_ff;
      bb_in      = bb_ff;
      cmd_pop    = 1'b0;
      load       = 1'b0;

      hdr_we    = 1'b0;
      hdr_waddr = '0;
      hdr_wdata = '0;
      hdr_raddr = '0;
      ftr_we    = 1'b0;
      ftr_waddr = '0;
      ftr_wdata = '0;
      ftr_raddr = '0;

      case (state_ff)
         S_CLEAR: begin
            // Sweep both tag memories; the first header covers the whole heap.
            hdr_we    = 1'b1;
            hdr_waddr = clr_ff;
            ftr_we    = 1'b1;
            ftr_waddr = clr_ff;
            if (clr_ff == '0) begin
               hdr_wdata = '{valid: 1'b1, is_free: 1'b1, size: SW'(bta_pkg::HEAP_GRANULES)};
            end
            if (clr_ff == '1) begin
               ftr_wdata = SW'(bta_pkg::HEAP_GRANULES);
               state_in  = S_IDLE;
            end
            clr_in = clr_ff + IW'(1);
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               st_in   = bta_pkg::ST_OK;
               ua_in   = '0;
               bb_in   = '0;
               cur_in  = '0;
               if (cmd.ign) begin
                  st_in    = bta_pkg::ST_IGNORED;
                  state_in = S_DONE;
               end else if (cmd.op == bta_pkg::OP_ALLOC) begin
                  state_in = S_A_RD;
               end else begin
                  state_in = S_F_RD;
               end
            end
         end
         S_A_RD: begin
            hdr_raddr = cur_ff[IW-1:0];
            state_in  = S_A_CHK;
         end
         S_A_CHK: begin
            if (!hdr_rd_ff.valid || hdr_rd_ff.size == '0) begin
               st_in    = bta_pkg::ST_NO_SPACE;
               state_in = S_DONE;
            end else if (hdr_rd_ff.is_free && NW'(hdr_rd_ff.size) >= cmd_ff.need) begin
               if ((NW+1)'(hdr_rd_ff.size) >=
                   (NW+1)'(cmd_ff.need) + (NW+1)'(bta_pkg::MIN_GRANULES)) begin
                  // Split: the tail becomes a new free block.
                  pb_base_in = cur_ff + PW'(cmd_ff.need);
                  pb_size_in = rem;
                  pb_free_in = 1'b1;
                  ret_in     = S_TAKE;
                  cnt_in     = cnt_ff + to_bytes(rem - PW'(2));
                  size_in    = PW'(cmd_ff.need);
                  state_in   = S_PB_H;
               end else begin
                  size_in  = PW'(hdr_rd_ff.size);
                  state_in = S_TAKE;
               end
            end else begin
               cur_in = cur_ff + PW'(hdr_rd_ff.size);
               if (cur_in >= HEAP_END) begin
                  st_in    = bta_pkg::ST_NO_SPACE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_A_RD;
               end
            end
         end
         S_TAKE: begin
            pb_base_in = cur_ff;
            pb_size_in = size_ff;
            pb_free_in = 1'b0;
            ret_in     = S_DONE;
            cnt_in     = cnt_ff - to_bytes(size_ff);
            ua_in      = bta_pkg::ADDR_W'(to_bytes(cur_ff) + CW'(bta_pkg::GRAN_BYTES));
            bb_in      = to_bbytes(size_ff);
            state_in   = S_PB_H;
         end
         S_F_RD: begin
            hdr_raddr = cmd_ff.hdr;
            state_in  = S_F_CHK;
         end
         S_F_CHK: begin
            if (!hdr_rd_ff.valid || hdr_rd_ff.is_free) begin
               st_in    = bta_pkg::ST_IGNORED;
               state_in = S_DONE;
            end else begin
               hdr_we    = 1'b1;
               hdr_waddr = cmd_ff.hdr;
               hdr_wdata = '{valid: 1'b1, is_free: 1'b1, size: hdr_rd_ff.size};
               size_in   = PW'(hdr_rd_ff.size);
               cnt_in    = cnt_ff + to_bytes(PW'(hdr_rd_ff.size));
               bb_in     = to_bbytes(PW'(hdr_rd_ff.size));
               state_in  = S_F_NRD;
            end
         end
         S_F_NRD: begin
            if (nxt < HEAP_END) begin
               hdr_raddr = nxt[IW-1:0];
               state_in  = S_F_NCHK;
            end else begin
               state_in = S_F_PREV;
            end
         end
         S_F_NCHK: begin
            if (hdr_rd_ff.valid && hdr_rd_ff.is_free) begin
               size_in    = size_ff + PW'(hdr_rd_ff.size);
               cnt_in     = cnt_ff - bta_pkg::OVERHEAD_BYTES;
               pb_base_in = PW'(cmd_ff.hdr);
               pb_size_in = size_in;
               pb_free_in = 1'b1;
               ret_in     = S_F_PREV;
               bb_in      = to_bbytes(size_in);
               state_in   = S_PB_H;
            end else begin
               state_in = S_F_PREV;
            end
         end
         S_F_PREV: begin
            if (cmd_ff.hdr != '0) begin
               ftr_raddr = cmd_ff.hdr - IW'(1);
               state_in  = S_F_FCHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_F_FCHK: begin
            // A zero footer or one reaching before the heap means no neighbor.
            if (ftr_rd_ff != '0 && ftr_rd_ff <= SW'(cmd_ff.hdr)) begin
               prev_in  = IW'(SW'(cmd_ff.hdr) - ftr_rd_ff);
               state_in = S_F_PRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_F_PRD: begin
            hdr_raddr = prev_ff;
            state_in  = S_F_PCHK;
         end
         S_F_PCHK: begin
            if (hdr_rd_ff.valid && hdr_rd_ff.is_free) begin
               size_in    = size_ff + PW'(hdr_rd_ff.size);
               cnt_in     = cnt_ff - bta_pkg::OVERHEAD_BYTES;
               pb_base_in = PW'(prev_ff);
               pb_size_in = size_in;
               pb_free_in = 1'b1;
               ret_in     = S_DONE;
               bb_in      = to_bbytes(size_in);
               state_in   = S_PB_H;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PB_H: begin
            if (pb_base_ff < HEAP_END) begin
               hdr_we    = 1'b1;
               hdr_waddr = pb_base_ff[IW-1:0];
               hdr_wdata = '{valid: 1'b1, is_free: pb_free_ff, size: pb_size_ff[SW-1:0]};
            end
            if (foot_ok) begin
               ftr_we    = 1'b1;
               ftr_waddr = pb_foot[IW-1:0];
               ftr_wdata = pb_size_ff[SW-1:0];
            end
            state_in = S_PB_F;
         end
         S_PB_F: begin
            // A footer granule never holds a live header.
            if (foot_ok && pb_foot != pb_base_ff) begin
               hdr_we    = 1'b1;
               hdr_waddr = pb_foot[IW-1:0];
               hdr_wdata = '0;
            end
            state_in = ret_ff;
         end
         S_DONE: begin
            if (!out_v_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_v_in = load || (out_v_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_mem[hdr_waddr] <= hdr_wdata;
      end
      hdr_rd_ff <= hdr_mem[hdr_raddr];
      if (ftr_we) begin
         ftr_mem[ftr_waddr] <= ftr_wdata;
      end
      ftr_rd_ff <= ftr_mem[ftr_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= bta_pkg::CNT_RESET;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
         out_v_ff <= out_v_in;
      end
      ret_ff     <= ret_in;
      cmd_ff     <= cmd_in;
      cur_ff     <= cur_in;
      size_ff    <= size_in;
      prev_ff    <= prev_in;
      pb_base_ff <= pb_base_in;
      pb_size_ff <= pb_size_in;
      pb_free_ff <= pb_free_in;
      st_ff      <= st_in;
      ua_ff      <= ua_in;
      bb_ff      <= bb_in;
      if (load) begin
         o_st_ff  <= st_ff;
         o_ua_ff  <= ua_ff;
         o_bb_ff  <= bb_ff;
         o_cnt_ff <= cnt_ff;
      end
   end

endmodule

/* rtl/core/boundary_tag_first_fit_allocator.sv */
// Allocate walks the block headers in order and, on a split, writes the free tail's tags first;
// free merges with free neighbors; a zero-size allocate or misaligned free is answered as ignored.
// Throughput: one transaction at a time in the engine; the walk reads one header at a
// time through the single header read port, so long block chains set the rate.
// Reset is synchronous: afterwards a pass initializes the tag memories, and
// no request is taken until it ends.
module boundary_tag_first_fit_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // op
   input  logic [39:0] req_tdata,   // req_bytes[20:0], addr[36:21], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [71:0] rsp_tdata    // user_addr[15:0], block_bytes[32:16], free_count[64:33]
);

   logic             init_done, f_valid, q_not_full, q_not_empty, q_pop;
   bta_pkg::cmd_type f_cmd, q_cmd;
   logic [bta_pkg::ADDR_W-1:0]  uaddr;
   logic [bta_pkg::BYTES_W-1:0] bbytes;
   logic [bta_pkg::CNT_W-1:0]   count;

   bta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (init_done),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_bytes  (req_tdata[20:0]),
      .req_addr   (req_tdata[36:21]),
      .cmd_valid  (f_valid),
      .cmd_ready  (q_not_full),
      .cmd        (f_cmd)
   );

   bta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_cmd  (f_cmd),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_cmd   (q_cmd)
   );

   bta_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .ready_init (init_done),
      .cmd_valid  (q_not_empty),
      .cmd_pop    (q_pop),
      .cmd        (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_uaddr  (uaddr),
      .rsp_bbytes (bbytes),
      .rsp_count  (count)
   );

   assign rsp_tdata = {7'b0, count, bbytes, uaddr};

endmodule
